// ===== hdl/ipsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IP prefix set match block.
// No dependencies; used by ipsm_cell and ip_prefix_set_match_top.
package ipsm_pkg;

    localparam int unsigned TableSlotsDflt = 64;
    localparam int unsigned AddrW          = 128;
    localparam int unsigned LenW           = 8;
    localparam logic [LenW-1:0] V4MaxLen   = 8'd32;
    localparam logic [LenW-1:0] V6MaxLen   = 8'd128;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_COVERED  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_ACT  = 3'b100
    } t_state;

    // query broadcast along the row of cells; addr already masked to len
    typedef struct packed {
        logic             fam;
        logic [AddrW-1:0] addr;
        logic [LenW-1:0]  len;
    } t_query;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_cell_ctl;

    // leading-ones mask of len bits over a 128-bit address (len 0..128)
    function automatic logic [AddrW-1:0] lead_mask(input logic [LenW-1:0] len);
        logic [AddrW-1:0] ones;
        ones = '1;
        lead_mask = ~(ones >> len);
    endfunction

endpackage

// ===== hdl/ipsm_cell.sv =====
`timescale 1ns / 1ps
// One table slot: stored prefix plus registered compare against the query.
// Depends on ipsm_pkg.
module ipsm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipsm_pkg::t_query   i_query,
    input  ipsm_pkg::t_cell_ctl i_ctl,
    output logic               o_valid,
    output logic               o_match,
    output logic               o_cov
);

    logic                        r_valid;
    logic                        r_fam;
    logic [ipsm_pkg::AddrW-1:0]  r_prefix;
    logic [ipsm_pkg::LenW-1:0]   r_len;
    logic                        r_match;
    logic                        r_cov;
    logic                        n_match;
    logic                        n_le;
    logic [ipsm_pkg::LenW-1:0]   w_min;

    always_comb begin
        n_le    = (r_len <= i_query.len);
        w_min   = n_le ? r_len : i_query.len;
        n_match = r_valid && (r_fam == i_query.fam) &&
                  (((r_prefix ^ i_query.addr) & ipsm_pkg::lead_mask(w_min)) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.wr) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_fam    <= i_query.fam;
            r_prefix <= i_query.addr;
            r_len    <= i_query.len;
        end
        r_match <= n_match;
        r_cov   <= n_match && n_le;
    end

    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_cov   = r_cov;

endmodule

// ===== hdl/ip_prefix_set_match_top.sv =====
`timescale 1ns / 1ps
// IP prefix set match: top level, row of slot cells and control sequencer.
// Depends on ipsm_pkg and ipsm_cell.
//
// Usage:
//   Slave channel carries one command beat: tuser selects operation (bit 0,
//   0 add, 1 check) and family (bit 1, 0 IPv4, 1 IPv6); tdata carries the
//   address and prefix length. Master channel returns one beat per command
//   with found and status.
//   Each command passes through a compare state, in which every cell
//   compares its slot against the query and registers the result, and
//   then an update state, in which the hits are reduced, the table
//   updated and the result loaded. A new command is accepted only while
//   idle or as the update state finishes, so commands do not overlap.
//   The result sits in an output register; a new command is taken while it
//   waits. If the receiver stalls, the second command holds in its update
//   cycle until the output register frees, and no further beat is taken.
//   Synchronous reset empties the table at once (per-slot valid bits) and
//   drops any pending result.
module ip_prefix_set_match_top #(
    parameter int unsigned TABLE_SLOTS = ipsm_pkg::TableSlotsDflt
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [63:0] addr_hi, [127:64] addr_lo, [135:128] prefix_len
    input  logic [135:0] i_s_axis_tdata,
    // [0] operation, [1] family
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [0] found, [2:1] status, [7:3] zero
    output logic [7:0]   o_m_axis_tdata
);

    ipsm_pkg::t_state    r_state, n_state;
    ipsm_pkg::t_query    r_query, n_query;
    logic                r_op;
    logic                r_too_long, n_too_long;
    logic                r_o_valid;
    logic                r_found;
    ipsm_pkg::t_status   r_status, n_status;
    logic                n_found;

    logic [TABLE_SLOTS-1:0] w_valid, w_match, w_cov;
    logic [TABLE_SLOTS-1:0] w_post, w_free, w_wr, w_clr;
    logic                   w_accept, w_out_free, w_finish, w_store;

    logic [63:0]                w_hi, w_lo;
    logic [ipsm_pkg::LenW-1:0]  w_len;
    logic                       w_fam;
    logic [ipsm_pkg::AddrW-1:0] w_addr;

    assign w_hi  = i_s_axis_tdata[63:0];
    assign w_lo  = i_s_axis_tdata[127:64];
    assign w_len = i_s_axis_tdata[135:128];
    assign w_fam = i_s_axis_tuser[1];

    always_comb begin
        // IPv4 keeps only the top 32 bits of addr_hi
        w_addr = w_fam ? {w_hi, w_lo} : {w_hi[63:32], 96'd0};
        n_query.fam  = w_fam;
        n_query.len  = w_len;
        n_query.addr = w_addr & ipsm_pkg::lead_mask(w_len);
        n_too_long   = w_fam ? (w_len > ipsm_pkg::V6MaxLen)
                             : (w_len > ipsm_pkg::V4MaxLen);
    end

    assign w_out_free      = !r_o_valid || i_m_axis_tready;
    assign w_finish        = (r_state == ipsm_pkg::S_ACT) && w_out_free;
    assign o_s_axis_tready = (r_state == ipsm_pkg::S_IDLE) || w_finish;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // drop matched (longer) prefixes, then pick the lowest free slot
    assign w_post = w_valid & ~w_match;
    assign w_free = ~w_post & (w_post + TABLE_SLOTS'(1));

    always_comb begin
        n_found  = 1'b0;
        n_status = ipsm_pkg::ST_OK;
        w_store  = 1'b0;
        priority if (r_too_long) begin
            n_status = ipsm_pkg::ST_TOO_LONG;
        end else if (r_op == ipsm_pkg::OP_CHECK) begin
            n_found = |w_match;
        end else if (|w_cov) begin
            n_status = ipsm_pkg::ST_COVERED;
        end else if (&w_post) begin
            n_status = ipsm_pkg::ST_FULL;
        end else begin
            w_store = 1'b1;
        end
    end

    assign w_wr  = (w_finish && w_store) ? w_free : '0;
    assign w_clr = (w_finish && w_store) ? w_match : '0;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        ipsm_pkg::t_cell_ctl w_ctl;
        assign w_ctl.wr  = w_wr[g];
        assign w_ctl.clr = w_clr[g];
        ipsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (r_query),
            .i_ctl   (w_ctl),
            .o_valid (w_valid[g]),
            .o_match (w_match[g]),
            .o_cov   (w_cov[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipsm_pkg::S_IDLE: if (w_accept) n_state = ipsm_pkg::S_CMP;
            ipsm_pkg::S_CMP:  n_state = ipsm_pkg::S_ACT;
            ipsm_pkg::S_ACT: begin
                if (w_finish) n_state = w_accept ? ipsm_pkg::S_CMP : ipsm_pkg::S_IDLE;
            end
            default:          n_state = ipsm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ipsm_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query    <= n_query;
            r_op       <= i_s_axis_tuser[0];
            r_too_long <= n_too_long;
        end
        if (w_finish) begin
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {5'd0, r_status, r_found};

`ifndef SYNTH
    a_found_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_found |-> r_status == ipsm_pkg::ST_OK)
        else $error("found set with non-ok status");
    a_one_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wr))
        else $error("more than one slot written");
    a_act_after_cmp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ipsm_pkg::S_CMP |=> r_state == ipsm_pkg::S_ACT)
        else $error("compare cycle not followed by update");
    a_no_write_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish && n_status == ipsm_pkg::ST_FULL |-> w_match == '0)
        else $error("full table with pending removal");
`endif

endmodule

// ===== dv/ip_prefix_set_match_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ip_prefix_set_match_top: directed and random add/check
// beats against an in-bench prefix table model. Depends on ipsm_pkg and the RTL.
module ip_prefix_set_match_top_test;

    localparam int NSLOT = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        ipsm_pkg::t_op op;
        logic          fam;
        logic [63:0]   hi;
        logic [63:0]   lo;
        logic [7:0]    len;
    } t_cmd;

    typedef struct {
        logic              found;
        ipsm_pkg::t_status status;
    } t_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [135:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [7:0]   o_m_axis_tdata;

    ip_prefix_set_match_top dut (.*);

    t_cmd cmd_q[$];
    t_res res_q[$];
    int   errors = 0;
    int   cycles = 0;
    bit   stim_done = 0;

    // model table
    logic         tab_vld[NSLOT];
    logic         tab_fam[NSLOT];
    logic [127:0] tab_pfx[NSLOT];
    logic [7:0]   tab_len[NSLOT];

    // saved prefixes for building related stimulus
    logic [127:0] seen_addr[$];

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    function automatic logic [127:0] mask_of(int len);
        logic [127:0] ones;
        ones = '1;
        if (len == 0) return '0;
        return ~(ones >> len);
    endfunction

    function automatic bit hits(int i, logic fam, logic [127:0] a, int len);
        int m;
        if (!tab_vld[i] || tab_fam[i] != fam) return 0;
        m = (tab_len[i] < len) ? tab_len[i] : len;
        return ((tab_pfx[i] ^ a) & mask_of(m)) == '0;
    endfunction

    function automatic t_res apply_cmd(t_cmd c);
        t_res r;
        logic [127:0] a;
        int maxl;
        bit cov;
        int fr;
        r.found = 0;
        r.status = ipsm_pkg::ST_OK;
        a = {c.hi, c.lo};
        if (!c.fam) a = {c.hi[63:32], 96'd0};
        maxl = c.fam ? 128 : 32;
        if (c.len > maxl) begin
            r.status = ipsm_pkg::ST_TOO_LONG;
        end else if (c.op == ipsm_pkg::OP_CHECK) begin
            for (int i = 0; i < NSLOT; i++) if (hits(i, c.fam, a, c.len)) r.found = 1;
        end else begin
            cov = 0;
            for (int i = 0; i < NSLOT; i++)
                if (hits(i, c.fam, a, c.len) && tab_len[i] <= c.len) cov = 1;
            if (cov) begin
                r.status = ipsm_pkg::ST_COVERED;
            end else begin
                for (int i = 0; i < NSLOT; i++) if (hits(i, c.fam, a, c.len)) tab_vld[i] = 0;
                fr = -1;
                for (int i = 0; i < NSLOT; i++) if (!tab_vld[i] && fr < 0) fr = i;
                if (fr < 0) begin
                    r.status = ipsm_pkg::ST_FULL;
                end else begin
                    tab_vld[fr] = 1;
                    tab_fam[fr] = c.fam;
                    tab_pfx[fr] = a & mask_of(c.len);
                    tab_len[fr] = c.len;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push(ipsm_pkg::t_op op, logic fam, logic [63:0] hi, logic [63:0] lo,
                        logic [7:0] len);
        t_cmd c;
        c.op = op; c.fam = fam; c.hi = hi; c.lo = lo; c.len = len;
        cmd_q.push_back(c);
        seen_addr.push_back({hi, lo});
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    initial begin
        logic [127:0] base;
        logic fam;
        int len;
        int sel;
        for (int i = 0; i < NSLOT; i++) tab_vld[i] = 0;
        // directed: extremes, zero length, too long, covered, removal
        push(ipsm_pkg::OP_CHECK, 0, '1, '1, 8'd0);
        push(ipsm_pkg::OP_ADD, 0, 64'hC0A8_0000_FFFF_FFFF, '1, 8'd16);
        push(ipsm_pkg::OP_CHECK, 0, 64'hC0A8_1234_0000_0000, '0, 8'd32);
        push(ipsm_pkg::OP_ADD, 0, 64'hC0A8_1200_0000_0000, '0, 8'd24);
        push(ipsm_pkg::OP_ADD, 0, 64'hC0A8_0000_0000_0000, '0, 8'd32);
        push(ipsm_pkg::OP_ADD, 0, '0, '0, 8'd33);
        push(ipsm_pkg::OP_CHECK, 0, '0, '0, 8'd255);
        push(ipsm_pkg::OP_ADD, 1, '1, '1, 8'd128);
        push(ipsm_pkg::OP_ADD, 1, 64'hFFFF_0000_0000_0000, '0, 8'd64);
        push(ipsm_pkg::OP_ADD, 1, '1, 64'h8000_0000_0000_0000, 8'd65);
        push(ipsm_pkg::OP_CHECK, 1, '1, '1, 8'd128);
        push(ipsm_pkg::OP_ADD, 1, '1, '1, 8'd8);
        push(ipsm_pkg::OP_ADD, 1, '0, '0, 8'd129);
        push(ipsm_pkg::OP_CHECK, 1, '0, '0, 8'd0);
        push(ipsm_pkg::OP_ADD, 1, '0, '0, 8'd0);
        push(ipsm_pkg::OP_ADD, 1, '1, '0, 8'd128);
        push(ipsm_pkg::OP_ADD, 0, '0, '0, 8'd0);
        push(ipsm_pkg::OP_CHECK, 0, 64'h1234_5678_9ABC_DEF0, '1, 8'd32);
        // add IPv4 /32 hosts beyond the slot count; the IPv4 /0 above covers them
        for (int i = 0; i < 70; i++)
            push(ipsm_pkg::OP_ADD, 0, {32'h0A00_0000 + i, 32'd0}, '0, 8'd32);
        push(ipsm_pkg::OP_CHECK, 0, 64'h0A00_0005_0000_0000, '0, 8'd32);
        push(ipsm_pkg::OP_ADD, 0, 64'h0A00_0000_0000_0000, '0, 8'd8);
        for (int n = 0; n < 1000; n++) begin
            fam = $urandom_range(0, 1);
            sel = $urandom_range(0, 9);
            if (sel < 6 && seen_addr.size() > 0)
                base = seen_addr[$urandom_range(0, seen_addr.size() - 1)];
            else
                base = {rand64(), rand64()};
            if (sel == 0) base = base ^ (128'd1 << $urandom_range(0, 127));
            if (sel == 9) len = $urandom_range(0, 255);
            else len = $urandom_range(0, fam ? 128 : 32);
            if ($urandom_range(0, 3) == 0) len = (len > 0) ? len - 1 : 0;
            // short IPv4 lengths often, so coverage and removal occur
            if (!fam && sel < 3) len = $urandom_range(0, 12);
            push(ipsm_pkg::t_op'($urandom_range(0, 1)), fam, base[127:64], base[63:0],
                 len[7:0]);
            // occasional purge keeps the table from saturating
            if ($urandom_range(0, 150) == 0)
                push(ipsm_pkg::OP_ADD, fam, rand64(), rand64(), 8'd0);
        end
        stim_done = 1;
    end

    // beat accepted at the last rising edge
    logic o_s_axis_tready_q = 0;
    always @(posedge i_clk) o_s_axis_tready_q <= i_s_axis_tvalid && o_s_axis_tready;

    // driver
    int gap = 0;
    int ogap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready_q) begin
            if (gap > 0) begin
                gap <= gap - 1;
                i_s_axis_tvalid <= 0;
            end else if (cmd_q.size() > 0) begin
                t_cmd c;
                c = cmd_q.pop_front();
                res_q.push_back(apply_cmd(c));
                i_s_axis_tdata <= {c.len, c.lo, c.hi};
                i_s_axis_tuser <= {c.fam, c.op};
                i_s_axis_tvalid <= 1;
                gap <= rand_gap();
            end else begin
                i_s_axis_tvalid <= 0;
            end
        end
        if (ogap > 0) begin
            ogap <= ogap - 1;
            i_m_axis_tready <= 0;
        end else begin
            i_m_axis_tready <= 1;
            ogap <= rand_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (res_q.size() == 0) begin
                $error("unexpected beat: tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                e = res_q.pop_front();
                if (o_m_axis_tdata[0] !== e.found) begin
                    $error("found: expected %0d, actual %0d", e.found, o_m_axis_tdata[0]);
                    errors++;
                end
                if (o_m_axis_tdata[2:1] !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_m_axis_tdata[2:1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;
        wait (stim_done && cmd_q.size() == 0 && !i_s_axis_tvalid && res_q.size() == 0
              || cycles > CYCLE_LIMIT);
        repeat (10) @(posedge i_clk);
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
        end else if (errors == 0 && res_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/ipsm_pkg.sv
hdl/ipsm_cell.sv
hdl/ip_prefix_set_match_top.sv
dv/ip_prefix_set_match_top_test.sv
